// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge out of reset
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/ucs_pkg.sv =====
package ucs_pkg;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_in;
  } in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic [3:0] component;
    logic       last_out;
    logic       has_user_info;
    logic [2:0] status;
  } res_t;

  typedef struct packed {
    logic push_a;
    logic push_b;
    res_t word_a;
    res_t word_b;
  } push_t;

  localparam logic [3:0] C_SCHEME = 4'd0;
  localparam logic [3:0] C_DELIM  = 4'd1;
  localparam logic [3:0] C_AUTH1  = 4'd2;
  localparam logic [3:0] C_AUTH2  = 4'd3;
  localparam logic [3:0] C_HOST   = 4'd4;
  localparam logic [3:0] C_PORT   = 4'd5;
  localparam logic [3:0] C_PATH   = 4'd6;
  localparam logic [3:0] C_QUERY  = 4'd7;
  localparam logic [3:0] C_FRAG   = 4'd8;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_COLON   = 3'd1;
  localparam logic [2:0] ST_BAD_SCHEME = 3'd2;
  localparam logic [2:0] ST_BAD_USER   = 3'd3;
  localparam logic [2:0] ST_BAD_CRED   = 3'd4;
  localparam logic [2:0] ST_BAD_PORT   = 3'd5;

endpackage

// ===== design/ucs_front.sv =====
`include "assert_macros.svh"

module ucs_front
  import ucs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  in_t   in_i,
  input  logic  space_ok_i,
  output push_t push_o
);

  localparam logic [3:0] PH_SCHEME = 4'd0;
  localparam logic [3:0] PH_COLON  = 4'd1;
  localparam logic [3:0] PH_AUTH1  = 4'd2;
  localparam logic [3:0] PH_AUTH2  = 4'd3;
  localparam logic [3:0] PH_HOST   = 4'd4;
  localparam logic [3:0] PH_PORT   = 4'd5;
  localparam logic [3:0] PH_PATH   = 4'd6;
  localparam logic [3:0] PH_QUERY  = 4'd7;
  localparam logic [3:0] PH_FRAG   = 4'd8;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_QUEST = 8'h3f;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic is_plain(logic [7:0] c);
    logic r;
    r = is_alpha(c) || is_digit(c);
    case (c)
      8'h2d, 8'h2e, 8'h5f, 8'h7e, 8'h21, 8'h24, 8'h26, 8'h27,
      8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h3b, 8'h3d, 8'h3a: r = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  // returns {good, escape progress}
  function automatic logic [2:0] ui_step(logic good, logic [1:0] esc, logic [7:0] c);
    logic       g;
    logic [1:0] e;
    g = good;
    e = esc;
    if (esc != 2'd0) begin
      if (is_hex(c)) begin
        e = (esc == 2'd1) ? 2'd2 : 2'd0;
      end else begin
        g = 1'b0;
        e = 2'd0;
      end
    end else if (c == CH_PCT) begin
      e = 2'd1;
    end else if (!is_plain(c)) begin
      g = 1'b0;
    end
    return {g, e};
  endfunction

  logic [3:0] phase_q, phase_d;
  logic       slash_q, slash_d;
  logic       scheme_good_q, scheme_good_d;
  logic       scheme_started_q, scheme_started_d;
  logic [1:0] esc_q, esc_d;
  logic       ui1_good_q, ui1_good_d;
  logic       second_present_q, second_present_d;
  logic       ui2_good_q, ui2_good_d;
  logic       digits2_good_q, digits2_good_d;
  logic       at_seen_q, at_seen_d;
  logic       late_port_q, late_port_d;
  logic       late_good_q, late_good_d;
  logic       part_started_q, part_started_d;

  logic       fire;
  logic [7:0] c;
  logic       hold;
  logic       pair;
  logic       skip_adv;
  logic [3:0] ph;
  logic [3:0] comp;
  logic [3:0] slash_comp;
  logic [2:0] status;
  logic [2:0] ui;

  assign fire = in_valid_i && space_ok_i;
  assign c    = in_i.char_in;

  always_comb begin
    phase_d          = phase_q;
    slash_d          = slash_q;
    scheme_good_d    = scheme_good_q;
    scheme_started_d = scheme_started_q;
    esc_d            = esc_q;
    ui1_good_d       = ui1_good_q;
    second_present_d = second_present_q;
    ui2_good_d       = ui2_good_q;
    digits2_good_d   = digits2_good_q;
    at_seen_d        = at_seen_q;
    late_port_d      = late_port_q;
    late_good_d      = late_good_q;
    part_started_d   = part_started_q;
    hold       = 1'b0;
    pair       = 1'b0;
    skip_adv   = 1'b0;
    ph         = phase_q;
    comp       = C_FRAG;
    slash_comp = C_PATH;
    status     = ST_OK;
    ui         = 3'd0;

    if (slash_q) begin
      slash_d = 1'b0;
      pair    = 1'b1;
      if (c == CH_SLASH) begin
        slash_comp = C_DELIM;
        comp       = C_DELIM;
        phase_d    = PH_AUTH1;
        skip_adv   = 1'b1;
      end else begin
        ph = PH_PATH;
      end
    end else if (phase_q == PH_COLON && c == CH_SLASH && !in_i.last_in) begin
      hold    = 1'b1;
      slash_d = 1'b1;
    end

    if (!hold && !skip_adv) begin
      if (ph == PH_COLON) begin
        ph = PH_PATH;
      end
      phase_d = ph;
      unique case (ph)
        PH_SCHEME: begin
          if (c == CH_COLON) begin
            phase_d = PH_COLON;
            comp    = C_DELIM;
          end else begin
            if (!scheme_started_q) begin
              scheme_good_d = is_alpha(c);
            end else begin
              scheme_good_d = scheme_good_q && (is_alpha(c) || is_digit(c) ||
                              c == CH_PLUS || c == CH_MINUS || c == CH_DOT);
            end
            scheme_started_d = 1'b1;
            comp             = C_SCHEME;
          end
        end
        PH_AUTH1: begin
          if (c == CH_QUEST) begin
            phase_d = PH_QUERY;
            comp    = C_DELIM;
          end else if (c == CH_HASH) begin
            phase_d = PH_FRAG;
            comp    = C_DELIM;
          end else if (c == CH_SLASH) begin
            phase_d = PH_PATH;
            comp    = C_PATH;
          end else if (c == CH_COLON || c == CH_AT) begin
            ui1_good_d = ui1_good_q && (esc_q == 2'd0);
            esc_d      = 2'd0;
            comp       = C_DELIM;
            if (c == CH_COLON) begin
              second_present_d = 1'b1;
              part_started_d   = 1'b0;
              phase_d          = PH_AUTH2;
            end else begin
              at_seen_d = 1'b1;
              phase_d   = PH_HOST;
            end
          end else begin
            ui         = ui_step(ui1_good_q, esc_q, c);
            ui1_good_d = ui[2];
            esc_d      = ui[1:0];
            comp       = C_AUTH1;
          end
        end
        PH_AUTH2: begin
          if (c == CH_QUEST) begin
            phase_d = PH_QUERY;
            comp    = C_DELIM;
          end else if (c == CH_HASH) begin
            phase_d = PH_FRAG;
            comp    = C_DELIM;
          end else if (c == CH_SLASH) begin
            phase_d = PH_PATH;
            comp    = C_PATH;
          end else if (c == CH_AT) begin
            ui2_good_d = ui2_good_q && (esc_q == 2'd0);
            esc_d      = 2'd0;
            at_seen_d  = 1'b1;
            phase_d    = PH_HOST;
            comp       = C_DELIM;
          end else begin
            ui             = ui_step(ui2_good_q, esc_q, c);
            ui2_good_d     = ui[2];
            esc_d          = ui[1:0];
            digits2_good_d = part_started_q ? (digits2_good_q && is_digit(c)) : is_digit(c);
            part_started_d = 1'b1;
            comp           = C_AUTH2;
          end
        end
        PH_HOST: begin
          if (c == CH_QUEST) begin
            phase_d = PH_QUERY;
            comp    = C_DELIM;
          end else if (c == CH_HASH) begin
            phase_d = PH_FRAG;
            comp    = C_DELIM;
          end else if (c == CH_SLASH) begin
            phase_d = PH_PATH;
            comp    = C_PATH;
          end else if (c == CH_COLON) begin
            late_port_d    = 1'b1;
            part_started_d = 1'b0;
            phase_d        = PH_PORT;
            comp           = C_DELIM;
          end else begin
            comp = C_HOST;
          end
        end
        PH_PORT: begin
          if (c == CH_QUEST) begin
            phase_d = PH_QUERY;
            comp    = C_DELIM;
          end else if (c == CH_HASH) begin
            phase_d = PH_FRAG;
            comp    = C_DELIM;
          end else if (c == CH_SLASH) begin
            phase_d = PH_PATH;
            comp    = C_PATH;
          end else begin
            late_good_d    = part_started_q ? (late_good_q && is_digit(c)) : is_digit(c);
            part_started_d = 1'b1;
            comp           = C_PORT;
          end
        end
        PH_PATH: begin
          if (c == CH_QUEST) begin
            phase_d = PH_QUERY;
            comp    = C_DELIM;
          end else if (c == CH_HASH) begin
            phase_d = PH_FRAG;
            comp    = C_DELIM;
          end else begin
            comp = C_PATH;
          end
        end
        PH_QUERY: begin
          if (c == CH_HASH) begin
            phase_d = PH_FRAG;
            comp    = C_DELIM;
          end else begin
            comp = C_QUERY;
          end
        end
        default: comp = C_FRAG;
      endcase
    end

    if (phase_d == PH_SCHEME) begin
      status = ST_NO_COLON;
    end else if (!scheme_good_d) begin
      status = ST_BAD_SCHEME;
    end else if (at_seen_d) begin
      if (!ui1_good_d) begin
        status = ST_BAD_USER;
      end else if (second_present_d && !ui2_good_d) begin
        status = ST_BAD_CRED;
      end else if (late_port_d && !late_good_d) begin
        status = ST_BAD_PORT;
      end
    end else if (second_present_d && !digits2_good_d) begin
      status = ST_BAD_PORT;
    end

    push_o.push_a                = fire && pair;
    push_o.push_b                = fire && !hold;
    push_o.word_a.char_out       = CH_SLASH;
    push_o.word_a.component      = slash_comp;
    push_o.word_a.last_out       = 1'b0;
    push_o.word_a.has_user_info  = 1'b0;
    push_o.word_a.status         = ST_OK;
    push_o.word_b.char_out       = c;
    push_o.word_b.component      = comp;
    push_o.word_b.last_out       = in_i.last_in;
    push_o.word_b.has_user_info  = in_i.last_in && at_seen_d;
    push_o.word_b.status         = in_i.last_in ? status : ST_OK;

    // end of uri: back to the reset state
    if (in_i.last_in) begin
      phase_d          = PH_SCHEME;
      slash_d          = 1'b0;
      scheme_good_d    = 1'b0;
      scheme_started_d = 1'b0;
      esc_d            = 2'd0;
      ui1_good_d       = 1'b1;
      second_present_d = 1'b0;
      ui2_good_d       = 1'b1;
      digits2_good_d   = 1'b0;
      at_seen_d        = 1'b0;
      late_port_d      = 1'b0;
      late_good_d      = 1'b0;
      part_started_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_SCHEME;
      slash_q          <= 1'b0;
      scheme_good_q    <= 1'b0;
      scheme_started_q <= 1'b0;
      esc_q            <= 2'd0;
      ui1_good_q       <= 1'b1;
      second_present_q <= 1'b0;
      ui2_good_q       <= 1'b1;
      digits2_good_q   <= 1'b0;
      at_seen_q        <= 1'b0;
      late_port_q      <= 1'b0;
      late_good_q      <= 1'b0;
      part_started_q   <= 1'b0;
    end else if (fire) begin
      phase_q          <= phase_d;
      slash_q          <= slash_d;
      scheme_good_q    <= scheme_good_d;
      scheme_started_q <= scheme_started_d;
      esc_q            <= esc_d;
      ui1_good_q       <= ui1_good_d;
      second_present_q <= second_present_d;
      ui2_good_q       <= ui2_good_d;
      digits2_good_q   <= digits2_good_d;
      at_seen_q        <= at_seen_d;
      late_port_q      <= late_port_d;
      late_good_q      <= late_good_d;
      part_started_q   <= part_started_d;
    end
  end

  `ASSERT_ALWAYS(a_slash_after_colon, slash_q |-> (phase_q == PH_COLON))
  `ASSERT_NEXT(a_last_resets, fire && in_i.last_in, (phase_q == PH_SCHEME) && !slash_q && !at_seen_q)

endmodule

// ===== design/ucs_queue.sv =====
`include "assert_macros.svh"

module ucs_queue
  import ucs_pkg::*;
#(
  parameter int Depth = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  space_ok_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  out_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = PtrW + 1;

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q;
  logic [PtrW-1:0] rd_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] push_n;
  logic            pop;

  assign pop         = out_valid_o && out_ready_i;
  assign push_n      = CntW'(push_i.push_a) + CntW'(push_i.push_b);
  assign count_d     = count_q + push_n - CntW'(pop);
  assign space_ok_o  = count_q <= CntW'(Depth - 2);
  assign out_valid_o = count_q != '0;
  assign out_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.push_a && push_i.push_b) begin
      mem_q[wr_q]               <= push_i.word_a;
      mem_q[wr_q + PtrW'(1)]    <= push_i.word_b;
    end else if (push_i.push_b) begin
      mem_q[wr_q] <= push_i.word_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + push_n[PtrW-1:0];
      rd_q    <= rd_q + PtrW'(pop);
      count_q <= count_d;
    end
  end

  `ASSERT_ALWAYS(a_no_overflow, (push_i.push_a || push_i.push_b) |-> space_ok_o)
  `ASSERT_ALWAYS(a_count_bound, count_q <= CntW'(Depth))

endmodule

// ===== design/uri_component_splitter.sv =====
// Tags each URI byte with its component, one byte accepted per cycle while
// in_ready_o is high. The word for an accepted byte is queued and offered on the
// output from there. A '/' straight after the scheme colon yields no word; the
// byte after it yields two. The byte queue holds FifoDepth words (power of two,
// at least 2) and in_ready_o is high while two slots are free; with FifoDepth of
// 4 or more a steady one word per cycle flows with out_ready_i held high. The last
// word of a URI carries has_user_info and status; the parser then starts afresh.
`include "assert_macros.svh"

module uri_component_splitter
  import ucs_pkg::*;
#(
  parameter int FifoDepth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_o
);

  push_t push;
  logic  space_ok;
  logic  summary_ok;

  assign in_ready_o = space_ok;

  // summary fields stay clear except on the last word
  assign summary_ok = out_o.last_out || ((out_o.status == ST_OK) && !out_o.has_user_info);

  ucs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_i       (in_i),
    .space_ok_i (space_ok),
    .push_o     (push)
  );

  ucs_queue #(
    .Depth (FifoDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_ok_o  (space_ok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  `ASSERT_ALWAYS(a_summary_on_last, out_valid_o |-> summary_ok)

endmodule
